[rtl/core/battery_gauge_block_average_lookup_top_assert.svh]
// Assertion macros shared by the battery gauge RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef BATTERY_GAUGE_BLOCK_AVERAGE_LOOKUP_TOP_ASSERT_SVH
`define BATTERY_GAUGE_BLOCK_AVERAGE_LOOKUP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BGBAL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BGBAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`define BGBAL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define BGBAL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define BGBAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define BGBAL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/bgbal_pkg.sv]
// Types, codes and the charge table of the battery gauge.
// Used by the front, back and top modules; depends on nothing.
`timescale 1ns / 1ps
package bgbal_pkg;

	localparam int unsigned AVG_W = 12;
	localparam int unsigned MV_W = 13;
	localparam int unsigned PCT_W = 7;
	localparam int unsigned RECIP_SHIFT = 18;

	localparam logic [2:0] OP_BAT_SAMPLE = 3'd0;
	localparam logic [2:0] OP_SOL_SAMPLE = 3'd1;
	localparam logic [2:0] OP_TICK = 3'd2;
	localparam logic [2:0] OP_START_ONCE = 3'd3;
	localparam logic [2:0] OP_START_CONT = 3'd4;
	localparam logic [2:0] OP_STOP_CONT = 3'd5;
	localparam logic [2:0] OP_RESET_PCT = 3'd6;

	localparam logic [PCT_W-1:0] TABLE_TOP = 7'd99;
	localparam logic [3:0] SETTLE_LAST = 4'd10;
	// floor(x * RECIP5 / 2^18) equals floor(x / 5) for every x below 2^16.
	localparam logic [15:0] RECIP5 = 16'd52429;

	localparam logic [AVG_W-1:0] SOC_TABLE [0:99] = '{
		12'd3508, 12'd3518, 12'd3524, 12'd3534, 12'd3537,
		12'd3547, 12'd3552, 12'd3557, 12'd3562, 12'd3569,
		12'd3574, 12'd3579, 12'd3584, 12'd3589, 12'd3594,
		12'd3597, 12'd3602, 12'd3603, 12'd3608, 12'd3611,
		12'd3614, 12'd3618, 12'd3619, 12'd3623, 12'd3626,
		12'd3627, 12'd3631, 12'd3632, 12'd3636, 12'd3637,
		12'd3640, 12'd3644, 12'd3645, 12'd3650, 12'd3650,
		12'd3654, 12'd3656, 12'd3659, 12'd3663, 12'd3665,
		12'd3668, 12'd3672, 12'd3674, 12'd3678, 12'd3680,
		12'd3686, 12'd3691, 12'd3696, 12'd3701, 12'd3706,
		12'd3714, 12'd3720, 12'd3725, 12'd3734, 12'd3736,
		12'd3745, 12'd3752, 12'd3759, 12'd3763, 12'd3771,
		12'd3778, 12'd3783, 12'd3792, 12'd3799, 12'd3805,
		12'd3813, 12'd3820, 12'd3829, 12'd3836, 12'd3845,
		12'd3852, 12'd3861, 12'd3867, 12'd3875, 12'd3884,
		12'd3890, 12'd3899, 12'd3907, 12'd3916, 12'd3926,
		12'd3931, 12'd3942, 12'd3946, 12'd3955, 12'd3964,
		12'd3970, 12'd3981, 12'd3987, 12'd3996, 12'd4005,
		12'd4012, 12'd4021, 12'd4029, 12'd4038, 12'd4048,
		12'd4056, 12'd4063, 12'd4072, 12'd4081, 12'd4089
	};

	typedef enum logic [2:0] {
		CMD_BAT_SAMPLE,
		CMD_SOL_SAMPLE,
		CMD_TICK,
		CMD_START_ONCE,
		CMD_START_CONT,
		CMD_STOP_CONT,
		CMD_RESET_PCT,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		logic [2:0] op;
		logic [AVG_W-1:0] sample;
	} req_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [AVG_W-1:0] sample;
	} cmd_t;

	typedef struct packed {
		logic [PCT_W-1:0] percent;
		logic [MV_W-1:0] battery_voltage;
		logic [AVG_W-1:0] battery_average;
		logic [AVG_W-1:0] solar_average;
		logic [MV_W-1:0] solar_voltage;
		logic once_pending;
	} res_t;

endpackage

[rtl/core/bgbal_front.sv]
// Request front end: accepts requests, decodes the op into a command kind
// and queues commands for the back end. Depends on bgbal_pkg.
`timescale 1ns / 1ps
module bgbal_front (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input bgbal_pkg::req_t req,
	output logic cmd_valid,
	input logic cmd_ready,
	output bgbal_pkg::cmd_t cmd
);

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	bgbal_pkg::cmd_t queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	bgbal_pkg::cmd_kind_t kind;
	logic push;
	logic pop;

	always_comb begin
		case (req.op)
			bgbal_pkg::OP_BAT_SAMPLE: kind = bgbal_pkg::CMD_BAT_SAMPLE;
			bgbal_pkg::OP_SOL_SAMPLE: kind = bgbal_pkg::CMD_SOL_SAMPLE;
			bgbal_pkg::OP_TICK: kind = bgbal_pkg::CMD_TICK;
			bgbal_pkg::OP_START_ONCE: kind = bgbal_pkg::CMD_START_ONCE;
			bgbal_pkg::OP_START_CONT: kind = bgbal_pkg::CMD_START_CONT;
			bgbal_pkg::OP_STOP_CONT: kind = bgbal_pkg::CMD_STOP_CONT;
			bgbal_pkg::OP_RESET_PCT: kind = bgbal_pkg::CMD_RESET_PCT;
			default: kind = bgbal_pkg::CMD_NOP;
		endcase
	end

	assign req_ready = (fill_q != CNT_W'(QUEUE_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd = queue_q[rd_ptr_q];
	assign push = req_valid && req_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{kind: kind, sample: req.sample};
		end
	end

endmodule

[rtl/core/bgbal_back.sv]
// Command execution: block averaging with a reciprocal multiply, voltage scaling,
// the table search and the result register. Depends on bgbal_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "battery_gauge_block_average_lookup_top_assert.svh"
module bgbal_back #(
	parameter int unsigned SAMPLES_PER_AVERAGE = 8
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input bgbal_pkg::cmd_t cmd,
	output logic res_valid,
	input logic res_ready,
	output bgbal_pkg::res_t res
);

	localparam int unsigned AVG_W = bgbal_pkg::AVG_W;
	localparam int unsigned MV_W = bgbal_pkg::MV_W;
	localparam int unsigned PCT_W = bgbal_pkg::PCT_W;
	localparam int unsigned RECIP_SHIFT = bgbal_pkg::RECIP_SHIFT;
	localparam int unsigned CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
	localparam int unsigned SUM_W = $clog2(SAMPLES_PER_AVERAGE * (2 ** AVG_W - 1) + 1);
	localparam logic [CNT_W-1:0] N_CNT = CNT_W'(SAMPLES_PER_AVERAGE);
	// floor(x * DIV_RECIP / 2^DIV_SHIFT) equals floor(x / N) for every x below 2^SUM_W.
	localparam int unsigned DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
	localparam int unsigned RECIP_W = SUM_W + 1;
	localparam int unsigned PROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(((1 << DIV_SHIFT)
		+ SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_MV,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [SUM_W-1:0] bat_sum_q;
	logic [CNT_W-1:0] bat_cnt_q;
	logic [AVG_W-1:0] bat_avg_q;
	logic [MV_W-1:0] bat_mv_q;
	logic [SUM_W-1:0] sol_sum_q;
	logic [CNT_W-1:0] sol_cnt_q;
	logic [AVG_W-1:0] sol_avg_q;
	logic [MV_W-1:0] sol_mv_q;
	logic [PCT_W-1:0] pct_q;
	logic [MV_W-1:0] volt_q;
	logic once_q;
	logic cont_q;
	logic [3:0] settle_q;
	logic tgt_sol_q;
	logic [SUM_W-1:0] div_num_q;
	logic [31:0] prod_q;
	logic [PCT_W-1:0] srch_q;
	logic res_valid_q;
	bgbal_pkg::res_t res_q;

	logic sel_sol;
	logic [SUM_W-1:0] sel_sum;
	logic [CNT_W-1:0] sel_cnt;
	logic [SUM_W-1:0] add_sum;
	logic [CNT_W-1:0] add_cnt;
	logic active;
	logic fire;
	logic [PCT_W-1:0] start_pct;
	logic [PROD_W-1:0] quot_prod;
	logic [17:0] sol_x37;
	logic [15:0] mul_x;
	logic srch_go;

	always_comb begin
		sel_sol = (cmd.kind == bgbal_pkg::CMD_SOL_SAMPLE);
		sel_sum = sel_sol ? sol_sum_q : bat_sum_q;
		sel_cnt = sel_sol ? sol_cnt_q : bat_cnt_q;
		add_sum = sel_sum + SUM_W'(cmd.sample);
		add_cnt = sel_cnt + 1'b1;
		active = once_q || cont_q;
		fire = once_q && (settle_q > bgbal_pkg::SETTLE_LAST);
		start_pct = (pct_q > bgbal_pkg::TABLE_TOP) ? bgbal_pkg::TABLE_TOP : pct_q;

		quot_prod = PROD_W'(div_num_q) * PROD_W'(DIV_RECIP);

		// Solar scale is x*37/20, taken as (x*37 >> 2) / 5.
		sol_x37 = {1'b0, sol_avg_q, 5'b00000} + {4'b0000, sol_avg_q, 2'b00}
			+ {6'b000000, sol_avg_q};
		mul_x = tgt_sol_q ? sol_x37[17:2]
			: ({1'b0, bat_avg_q, 3'b000} - {4'b0000, bat_avg_q});

		srch_go = (srch_q != '0)
			&& !(bat_mv_q > {1'b0, bgbal_pkg::SOC_TABLE[srch_q]});
	end

	assign cmd_ready = (state_q == ST_IDLE) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bat_sum_q <= '0;
			bat_cnt_q <= '0;
			bat_avg_q <= '0;
			bat_mv_q <= '0;
			sol_sum_q <= '0;
			sol_cnt_q <= '0;
			sol_avg_q <= '0;
			sol_mv_q <= '0;
			pct_q <= bgbal_pkg::TABLE_TOP;
			volt_q <= '0;
			once_q <= 1'b0;
			cont_q <= 1'b0;
			settle_q <= '0;
			tgt_sol_q <= 1'b0;
			div_num_q <= '0;
			prod_q <= '0;
			srch_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						case (cmd.kind)
							bgbal_pkg::CMD_BAT_SAMPLE, bgbal_pkg::CMD_SOL_SAMPLE: begin
								if (active) begin
									tgt_sol_q <= sel_sol;
									div_num_q <= (sel_cnt < N_CNT) ? add_sum : sel_sum;
									if ((sel_cnt < N_CNT) && (add_cnt != N_CNT)) begin
										state_q <= ST_EMIT;
										if (sel_sol) begin
											sol_sum_q <= add_sum;
											sol_cnt_q <= add_cnt;
										end else begin
											bat_sum_q <= add_sum;
											bat_cnt_q <= add_cnt;
										end
									end else begin
										// Block complete: clear the channel and divide.
										state_q <= ST_DIV;
										if (sel_sol) begin
											sol_sum_q <= '0;
											sol_cnt_q <= '0;
										end else begin
											bat_sum_q <= '0;
											bat_cnt_q <= '0;
										end
									end
								end else begin
									state_q <= ST_EMIT;
								end
							end
							bgbal_pkg::CMD_TICK: begin
								if (once_q) begin
									settle_q <= fire ? 4'd0 : settle_q + 4'd1;
								end
								if (fire) begin
									once_q <= 1'b0;
								end
								// A continuous search overrides the one-shot result.
								if (cont_q) begin
									srch_q <= bgbal_pkg::TABLE_TOP;
									volt_q <= bat_mv_q;
									state_q <= ST_SEARCH;
								end else if (fire) begin
									srch_q <= start_pct;
									volt_q <= bat_mv_q;
									state_q <= ST_SEARCH;
								end else begin
									state_q <= ST_EMIT;
								end
							end
							bgbal_pkg::CMD_START_ONCE: begin
								settle_q <= '0;
								once_q <= 1'b1;
								cont_q <= 1'b0;
								state_q <= ST_EMIT;
							end
							bgbal_pkg::CMD_START_CONT: begin
								cont_q <= 1'b1;
								state_q <= ST_EMIT;
							end
							bgbal_pkg::CMD_STOP_CONT: begin
								cont_q <= 1'b0;
								state_q <= ST_EMIT;
							end
							bgbal_pkg::CMD_RESET_PCT: begin
								pct_q <= bgbal_pkg::TABLE_TOP;
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (tgt_sol_q) begin
						sol_avg_q <= quot_prod[DIV_SHIFT +: AVG_W];
					end else begin
						bat_avg_q <= quot_prod[DIV_SHIFT +: AVG_W];
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= {16'd0, mul_x} * {16'd0, bgbal_pkg::RECIP5};
					state_q <= ST_MV;
				end
				ST_MV: begin
					if (tgt_sol_q) begin
						sol_mv_q <= prod_q[RECIP_SHIFT +: MV_W];
					end else begin
						bat_mv_q <= prod_q[RECIP_SHIFT +: MV_W];
					end
					state_q <= ST_EMIT;
				end
				ST_SEARCH: begin
					if (srch_go) begin
						srch_q <= srch_q - 1'b1;
					end else begin
						pct_q <= srch_q;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					res_valid_q <= 1'b1;
					res_q <= '{
						percent: pct_q,
						battery_voltage: volt_q,
						battery_average: bat_avg_q,
						solar_average: sol_avg_q,
						solar_voltage: sol_mv_q,
						once_pending: once_q
					};
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BGBAL_ASSERT_ALWAYS(a_pct_in_table, clk, arst_n, pct_q <= bgbal_pkg::TABLE_TOP, "percent left the table")
	`BGBAL_ASSERT_ALWAYS(a_settle_bound, clk, arst_n, settle_q <= (bgbal_pkg::SETTLE_LAST + 4'd1), "settle count ran past the firing tick")
	`BGBAL_ASSERT_ALWAYS(a_block_count, clk, arst_n, (bat_cnt_q < N_CNT) && (sol_cnt_q < N_CNT), "block count reached the block size")
	`BGBAL_ASSERT_NEXT(a_cont_tick_search, clk, arst_n, cmd_valid && cmd_ready && (cmd.kind == bgbal_pkg::CMD_TICK) && cont_q, (state_q == ST_SEARCH) && (srch_q == bgbal_pkg::TABLE_TOP), "continuous tick did not search from the top")

endmodule

[rtl/core/battery_gauge_block_average_lookup_top.sv]
// Battery gauge: block averages of battery and solar ADC samples and a
// voltage-to-charge table lookup. Top level; depends on bgbal_pkg, bgbal_front
// and bgbal_back.
//
// Usage: each request on req carries an op code and a 12-bit sample; every
// request produces exactly one result on res, in request order, holding the
// percent, last looked-up battery voltage, both block averages, the solar
// voltage and the one-shot pending flag. Both channels use valid/ready.
// The front end queues up to two requests, so req stays ready while a result
// waits on a stalled receiver; once the queue is full, req_ready drops until
// res is taken.
// A request passes the front-end queue and the back end's idle and emit states
// before its result is valid. A sample that completes a block also passes the
// divide state, where the reciprocal multiply forms the average, and the
// scaling states ST_MUL and ST_MV. A tick that runs a lookup also passes the
// search state, one table entry per cycle. Requests are executed one at a time.
// Reset clears averages, voltages and modes and sets percent to 99.
`timescale 1ns / 1ps
module battery_gauge_block_average_lookup_top #(
	parameter int unsigned SAMPLES_PER_AVERAGE = 8
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input bgbal_pkg::req_t req,
	output logic res_valid,
	input logic res_ready,
	output bgbal_pkg::res_t res
);

	logic cmd_valid;
	logic cmd_ready;
	bgbal_pkg::cmd_t cmd;

	bgbal_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd)
	);

	bgbal_back #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

endmodule

[test/battery_gauge_block_average_lookup_top_tb.sv]
// Testbench for the battery gauge: block averages of battery and solar samples and the
// charge table lookup. Predicts every result in step with each request and checks it.
// Depends on bgbal_pkg and battery_gauge_block_average_lookup_top.
`timescale 1ns / 1ps
module battery_gauge_block_average_lookup_top_tb;

	localparam int unsigned BLOCK_SIZE = 8;
	localparam logic [2:0] OP_SPARE = 3'd7;
	localparam int unsigned TARGET_REQUESTS = 750;
	localparam int unsigned DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	bgbal_pkg::req_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	bgbal_pkg::res_t res;

	// Mirror of the gauge state, advanced once per accepted request.
	logic [14:0] bat_sum = '0;
	logic [14:0] sol_sum = '0;
	logic [3:0] bat_count = '0;
	logic [3:0] sol_count = '0;
	logic [11:0] bat_avg = '0;
	logic [11:0] sol_avg = '0;
	logic [6:0] charge_pct = bgbal_pkg::TABLE_TOP;
	logic [12:0] bat_mv = '0;
	logic once_active = 1'b0;
	logic cont_active = 1'b0;
	logic [3:0] settle_count = '0;

	bgbal_pkg::res_t expected_readings[$];
	bgbal_pkg::res_t due;
	int unsigned mismatch_count = 0;
	int unsigned counted_requests = 0;
	int unsigned burst_left = 0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;

	always #6 clk = ~clk;

	battery_gauge_block_average_lookup_top #(
		.SAMPLES_PER_AVERAGE(BLOCK_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	function automatic logic [12:0] battery_millivolts(input logic [11:0] avg);
		int unsigned t;
		t = avg;
		t = (t * 7) / 5;
		return t[12:0];
	endfunction

	// Walks down from the start point to the first entry the voltage exceeds.
	function automatic logic [6:0] charge_search(input logic [6:0] start, input logic [12:0] mv);
		logic [6:0] p;
		p = (start > bgbal_pkg::TABLE_TOP) ? bgbal_pkg::TABLE_TOP : start;
		while (p > 0 && !(mv > {1'b0, bgbal_pkg::SOC_TABLE[p]}))
			p--;
		return p;
	endfunction

	task automatic accumulate_block(input logic [11:0] code, inout logic [14:0] sum,
			inout logic [3:0] count, inout logic [11:0] avg);
		if (count < BLOCK_SIZE) begin
			count = count + 4'd1;
			sum = sum + 15'(code);
		end
		if (count >= BLOCK_SIZE) begin
			avg = 12'(sum / BLOCK_SIZE);
			sum = '0;
			count = '0;
		end
	endtask

	task automatic predict_reading(input bgbal_pkg::req_t r, output bgbal_pkg::res_t e);
		logic [3:0] prior;
		logic [12:0] mv;
		int unsigned sv;
		case (r.op)
			bgbal_pkg::OP_BAT_SAMPLE: begin
				if (once_active || cont_active)
					accumulate_block(r.sample, bat_sum, bat_count, bat_avg);
			end
			bgbal_pkg::OP_SOL_SAMPLE: begin
				if (once_active || cont_active)
					accumulate_block(r.sample, sol_sum, sol_count, sol_avg);
			end
			bgbal_pkg::OP_TICK: begin
				// The one-shot step runs first, then the continuous search.
				if (once_active) begin
					prior = settle_count;
					settle_count = settle_count + 4'd1;
					if (prior > bgbal_pkg::SETTLE_LAST) begin
						mv = battery_millivolts(bat_avg);
						settle_count = '0;
						once_active = 1'b0;
						charge_pct = charge_search(charge_pct, mv);
						bat_mv = mv;
					end
				end
				if (cont_active) begin
					mv = battery_millivolts(bat_avg);
					charge_pct = charge_search(bgbal_pkg::TABLE_TOP, mv);
					bat_mv = mv;
				end
			end
			bgbal_pkg::OP_START_ONCE: begin
				settle_count = '0;
				once_active = 1'b1;
				cont_active = 1'b0;
			end
			bgbal_pkg::OP_START_CONT: cont_active = 1'b1;
			bgbal_pkg::OP_STOP_CONT: cont_active = 1'b0;
			bgbal_pkg::OP_RESET_PCT: charge_pct = bgbal_pkg::TABLE_TOP;
			default: ;
		endcase
		e.percent = charge_pct;
		e.battery_voltage = bat_mv;
		e.battery_average = bat_avg;
		e.solar_average = sol_avg;
		sv = sol_avg;
		sv = (sv * 37) / 20;
		e.solar_voltage = sv[12:0];
		e.once_pending = once_active;
	endtask

	// Sends one request in bursts with random gaps and queues the predicted result.
	task automatic send_request(input logic [2:0] op, input logic [11:0] code);
		bgbal_pkg::req_t item;
		bgbal_pkg::res_t reading;
		int unsigned gap;
		int unsigned pick;
		logic ignored;
		if (burst_left == 0) begin
			pick = $urandom_range(0, 7);
			if (pick < 2)
				gap = 0;
			else if (pick == 7)
				gap = $urandom_range(20, 60);
			else
				gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item.op = op;
		item.sample = code;
		req <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		ignored = (op == bgbal_pkg::OP_BAT_SAMPLE || op == bgbal_pkg::OP_SOL_SAMPLE)
			&& !(once_active || cont_active);
		predict_reading(item, reading);
		expected_readings.push_back(reading);
		if (!ignored)
			counted_requests++;
	endtask

	function automatic logic [11:0] battery_code(input int unsigned level);
		int v;
		if ($urandom_range(0, 4) == 0)
			return 12'($urandom_range(0, 4095));
		v = int'(level) + int'($urandom_range(0, 80)) - 40;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	// One full battery block, with solar samples mixed in now and then.
	task automatic fill_battery_block(input int unsigned level);
		int unsigned flat;
		flat = $urandom_range(0, 11);
		for (int i = 0; i < BLOCK_SIZE; i++) begin
			if (flat == 0)
				send_request(bgbal_pkg::OP_BAT_SAMPLE, 12'h000);
			else if (flat == 1)
				send_request(bgbal_pkg::OP_BAT_SAMPLE, 12'hFFF);
			else
				send_request(bgbal_pkg::OP_BAT_SAMPLE, battery_code(level));
			if ($urandom_range(0, 2) == 0)
				send_request(bgbal_pkg::OP_SOL_SAMPLE, 12'($urandom_range(0, 4095)));
		end
	endtask

	task automatic test_idle_behavior;
		send_request(OP_SPARE, 12'hFFF);
		send_request(bgbal_pkg::OP_BAT_SAMPLE, 12'hFFF);
		send_request(bgbal_pkg::OP_SOL_SAMPLE, 12'h000);
		send_request(bgbal_pkg::OP_TICK, 12'h000);
		send_request(bgbal_pkg::OP_STOP_CONT, 12'hFFF);
		send_request(bgbal_pkg::OP_RESET_PCT, 12'h000);
	endtask

	task automatic test_continuous_extremes;
		send_request(bgbal_pkg::OP_START_CONT, 12'h000);
		for (int i = 0; i < BLOCK_SIZE; i++)
			send_request(bgbal_pkg::OP_BAT_SAMPLE, 12'hFFF);
		send_request(bgbal_pkg::OP_TICK, 12'hFFF);
		send_request(bgbal_pkg::OP_SOL_SAMPLE, 12'hFFF);
		send_request(bgbal_pkg::OP_SOL_SAMPLE, 12'h000);
	endtask

	task automatic test_mode_overlap;
		// Starting a one-shot drops continuous mode; restarting continuous keeps the one-shot.
		send_request(bgbal_pkg::OP_START_ONCE, 12'h000);
		send_request(bgbal_pkg::OP_START_CONT, 12'hFFF);
		send_request(bgbal_pkg::OP_TICK, 12'h000);
		send_request(bgbal_pkg::OP_STOP_CONT, 12'h000);
		send_request(bgbal_pkg::OP_TICK, 12'hFFF);
		send_request(bgbal_pkg::OP_RESET_PCT, 12'hFFF);
		send_request(OP_SPARE, 12'h000);
	endtask

	task automatic run_continuous_sequence;
		int unsigned level;
		send_request(bgbal_pkg::OP_START_CONT, 12'($urandom_range(0, 4095)));
		for (int k = 0; k < $urandom_range(1, 3); k++) begin
			level = $urandom_range(2480, 2940);
			fill_battery_block(level);
			for (int t = 0; t < $urandom_range(1, 3); t++)
				send_request(bgbal_pkg::OP_TICK, 12'($urandom_range(0, 4095)));
		end
		if ($urandom_range(0, 2) == 0)
			send_request(bgbal_pkg::OP_STOP_CONT, 12'($urandom_range(0, 4095)));
	endtask

	task automatic run_one_shot_sequence;
		int unsigned level;
		int unsigned ticks;
		level = $urandom_range(2480, 2940);
		if ($urandom_range(0, 3) == 0)
			send_request(bgbal_pkg::OP_RESET_PCT, 12'($urandom_range(0, 4095)));
		send_request(bgbal_pkg::OP_START_ONCE, 12'($urandom_range(0, 4095)));
		ticks = $urandom_range(11, 14);
		for (int t = 0; t < ticks; t++) begin
			if ($urandom_range(0, 3) == 0)
				fill_battery_block(level);
			if ($urandom_range(0, 15) == 0)
				send_request(bgbal_pkg::OP_START_CONT, 12'($urandom_range(0, 4095)));
			send_request(bgbal_pkg::OP_TICK, 12'($urandom_range(0, 4095)));
		end
		if ($urandom_range(0, 1) == 0)
			send_request(bgbal_pkg::OP_STOP_CONT, 12'($urandom_range(0, 4095)));
	endtask

	task automatic test_random_sequences;
		int unsigned pick;
		while (counted_requests < TARGET_REQUESTS) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				run_continuous_sequence();
			else if (pick < 8)
				run_one_shot_sequence();
			else begin
				for (int i = 0; i < $urandom_range(5, 15); i++)
					send_request(3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)));
			end
		end
	endtask

	task automatic compare_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	// The receiver switches between always ready, random and mostly stalled stretches.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(10, 200);
		end
		stall_left--;
		case (stall_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= ($urandom_range(0, 1) == 0);
			default: res_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_readings.size() == 0) begin
				$display("%0t ns: result with no request outstanding, expected none actual %h",
					$time, res);
				mismatch_count++;
			end else begin
				due = expected_readings.pop_front();
				compare_field("percent", 16'(due.percent), 16'(res.percent));
				compare_field("battery_voltage", 16'(due.battery_voltage),
					16'(res.battery_voltage));
				compare_field("battery_average", 16'(due.battery_average),
					16'(res.battery_average));
				compare_field("solar_average", 16'(due.solar_average),
					16'(res.solar_average));
				compare_field("solar_voltage", 16'(due.solar_voltage),
					16'(res.solar_voltage));
				compare_field("once_pending", 16'(due.once_pending),
					16'(res.once_pending));
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_behavior();
		test_continuous_extremes();
		test_mode_overlap();
		test_random_sequences();
		req_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[battery_gauge_block_average_lookup_top.f]
+incdir+rtl/core
rtl/core/bgbal_pkg.sv
rtl/core/bgbal_front.sv
rtl/core/bgbal_back.sv
rtl/core/battery_gauge_block_average_lookup_top.sv
test/battery_gauge_block_average_lookup_top_tb.sv
